FILE: rtl/wildcard_pattern_matcher_macros.svh
// ----------------------------------------------------------------------------
// Wildcard pattern matcher assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define WPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WPM_ASSERT_IMPL(lbl, ante, cons, msg)
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Opcodes, status codes, wildcard bytes and the request record that moves
// from cell to cell.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int MAX_PATTERN_DEF = 128;

  localparam logic [7:0] CHAR_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_ANY = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_TEXT    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_LATE = 2'd2
  } status_t;

  // one request as it walks down the chain
  typedef struct packed {
    logic       valid;
    opcode_t    op;
    logic [7:0] ch;
    logic       app_ok;  // append accepted at entry
    status_t    status;
    logic       nv;      // new match bit of the previous cell
    logic       od;      // old match bit of the previous cell
    logic       st;      // start bit of the previous cell
    logic       live;    // previous cell holds a pattern byte
    logic       res;     // match bit of the last used cell so far
  } wave_t;

endpackage

FILE: rtl/wpm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds one pattern byte with its start and match bits and updates them as
// a request passes by, then hands the request to the next cell.
// ----------------------------------------------------------------------------
module wpm_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  wpm_pkg::wave_t wave_in,
  output wpm_pkg::wave_t wave_out
);

  logic       used;
  logic [7:0] pch;
  logic       st;
  logic       m;

  logic       used_next;
  logic [7:0] pch_next;
  logic       st_next;
  logic       m_next;

  wpm_pkg::wave_t wave_next;

  always_comb begin
    used_next = used;
    pch_next  = pch;
    st_next   = st;
    m_next    = m;
    unique case (wave_in.op)
      wpm_pkg::OP_CLEAR: begin
        used_next = 1'b0;
      end
      wpm_pkg::OP_APPEND: begin
        // the first free cell behind the used prefix takes the byte
        if (wave_in.app_ok && wave_in.live && !used) begin
          used_next = 1'b1;
          pch_next  = wave_in.ch;
          st_next   = wave_in.st & (wave_in.ch == wpm_pkg::CHAR_ANY);
          m_next    = wave_in.st & (wave_in.ch == wpm_pkg::CHAR_ANY);
        end
      end
      wpm_pkg::OP_RESTART: begin
        m_next = st;
      end
      wpm_pkg::OP_TEXT: begin
        if (used) begin
          if (pch == wpm_pkg::CHAR_ANY) begin
            m_next = m | wave_in.nv;
          end else if (pch == wpm_pkg::CHAR_ONE || pch == wave_in.ch) begin
            m_next = wave_in.od;
          end else begin
            m_next = 1'b0;
          end
        end
      end
      default: begin
        used_next = used;
      end
    endcase
  end

  always_comb begin
    wave_next      = wave_in;
    wave_next.nv   = m_next;
    wave_next.od   = m;
    wave_next.st   = st_next;
    // a byte taken here must not be taken again further down
    wave_next.live = wave_in.live & used;
    wave_next.res  = (wave_in.live & used_next) ? m_next : wave_in.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (en && wave_in.valid) begin
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && wave_in.valid) begin
      pch <= pch_next;
      st  <= st_next;
      m   <= m_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else if (en) begin
      wave_out <= wave_next;
    end
  end

endmodule

FILE: rtl/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Streams text against a stored pattern where '?' matches one byte and '*'
// matches any run of bytes.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the opcode (clear, append pattern byte,
// restart text, text byte), s_tdata the byte. Every request gives exactly
// one response on the output stream: match in bit 0, status in bits 2:1.
// Requests travel down a row of MAX_PATTERN registered cells behind an entry
// register. The row is a pipeline: unless a stalled m_tready holds it, one
// request is taken every cycle, back to back, for every opcode, and star
// runs resolve as the request passes each cell.
// Status is decided at entry: append after text started, then store full.
// Reset empties the pattern, clears text state and drops requests in flight.
// A stalled m_tready freezes the whole row, including s_tready; the output
// register holds its response until taken.
// ----------------------------------------------------------------------------
`include "wildcard_pattern_matcher_macros.svh"

module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_value
  input  logic [1:0] s_tuser,   // opcode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // match, status, zero fill
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  wpm_pkg::wave_t wave [0:MAX_PATTERN];
  wpm_pkg::wave_t wave0_next;

  logic          en;
  logic          s_accept;
  wpm_pkg::opcode_t op;
  logic [LW-1:0] length;
  logic [LW-1:0] length_next;
  logic          text_started;
  logic          text_started_next;
  logic          m0;
  logic          m0_next;
  logic          app_ok;
  wpm_pkg::status_t status;

  assign en       = !wave[MAX_PATTERN].valid || m_tready;
  assign s_tready = en;
  assign s_accept = s_tvalid && en;
  assign op       = wpm_pkg::opcode_t'(s_tuser);

  always_comb begin
    app_ok = 1'b0;
    status = wpm_pkg::ST_OK;
    if (op == wpm_pkg::OP_APPEND) begin
      priority if (text_started) begin
        status = wpm_pkg::ST_LATE;
      end else if (length == LW'(MAX_PATTERN)) begin
        status = wpm_pkg::ST_FULL;
      end else begin
        app_ok = 1'b1;
      end
    end
  end

  always_comb begin
    length_next       = length;
    text_started_next = text_started;
    m0_next           = m0;
    unique case (op)
      wpm_pkg::OP_CLEAR: begin
        length_next       = '0;
        text_started_next = 1'b0;
        m0_next           = 1'b1;
      end
      wpm_pkg::OP_APPEND: begin
        if (app_ok) begin
          length_next = length + LW'(1);
        end
      end
      wpm_pkg::OP_RESTART: begin
        text_started_next = 1'b0;
        m0_next           = 1'b1;
      end
      wpm_pkg::OP_TEXT: begin
        text_started_next = 1'b1;
        m0_next           = 1'b0;
      end
      default: begin
        m0_next = m0;
      end
    endcase
  end

  // entry of the empty prefix, the head of the row
  always_comb begin
    wave0_next.valid  = s_tvalid;
    wave0_next.op     = op;
    wave0_next.ch     = s_tdata;
    wave0_next.app_ok = app_ok;
    wave0_next.status = status;
    wave0_next.nv     = m0_next;
    wave0_next.od     = m0;
    wave0_next.st     = 1'b1;
    wave0_next.live   = 1'b1;
    wave0_next.res    = m0_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length       <= '0;
      text_started <= 1'b0;
      m0           <= 1'b1;
    end else if (s_accept) begin
      length       <= length_next;
      text_started <= text_started_next;
      m0           <= m0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave[0].valid <= 1'b0;
    end else if (en) begin
      wave[0] <= wave0_next;
    end
  end

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    wpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .wave_in  (wave[j-1]),
      .wave_out (wave[j])
    );
  end

  assign m_tvalid = wave[MAX_PATTERN].valid;
  assign m_tdata  = {5'b0, wave[MAX_PATTERN].status, wave[MAX_PATTERN].res};

  `WPM_ASSERT_IMPL(a_len_bound, 1'b1, length <= LW'(MAX_PATTERN), "pattern length overflow")
  `WPM_ASSERT_NEXT(a_clear_match, s_accept && op == wpm_pkg::OP_CLEAR, wave[0].res, "clear must match")
  `WPM_ASSERT_NEXT(a_late_append, s_accept && op == wpm_pkg::OP_APPEND && text_started, wave[0].status == wpm_pkg::ST_LATE, "late append not flagged")
  `WPM_ASSERT_NEXT(a_head_text, s_accept && op == wpm_pkg::OP_TEXT, !m0, "empty prefix kept match after text")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern matcher testbench
// Directed table and then random sessions. A session is a clear (most of the
// time), a pattern of '*', '?' and literal bytes, and text runs drawn mostly
// from the pattern itself. Every response is checked against its typed table
// entry or an in-bench match-row predictor. Sender idle and receiver stall
// rates change by phase, and one long output hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAXP           = wpm_pkg::MAX_PATTERN_DEF;
  localparam int N_RANDOM       = 1600;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 2 * MAXP + 40;

  typedef struct {
    wpm_pkg::opcode_t op;
    logic [7:0]       ch;
    bit               typed;  // expected response written in the table
    logic             m;
    wpm_pkg::status_t st;
  } stim_t;

  typedef struct {
    logic             m;
    wpm_pkg::status_t st;
  } resp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // char_value
  logic [1:0] s_tuser = 2'b00;   // opcode
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // match, status, zero fill

  wildcard_pattern_matcher #(.MAX_PATTERN(MAXP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]    pat_mem [MAXP];
  int unsigned   pat_len;
  logic [MAXP:0] star_prefix;  // match bits for empty text
  logic [MAXP:0] hit_row;      // match bits for text so far
  bit            text_seen;

  stim_t stim_q[$];
  resp_t expected_resp_q[$];
  int    n_dir;
  int    n_rand;
  int    item_idx = 0;
  int    cur_phase = 0;
  bit    hold_rx = 1'b0;
  int    errors = 0;
  int    quiet_cycles = 0;
  int    resp_count = 0;
  int    match_ones = 0;
  int    full_seen = 0;
  int    late_seen = 0;
  int    in_stalls = 0;
  int    long_left = 4;
  int    session_no = 0;

  task automatic wildcard_step(input wpm_pkg::opcode_t op, input logic [7:0] ch,
                               output logic m, output wpm_pkg::status_t st);
    logic [MAXP:0] nxt;
    st = wpm_pkg::ST_OK;
    case (op)
      wpm_pkg::OP_CLEAR: begin
        pat_len     = 0;
        star_prefix = '0;
        star_prefix[0] = 1'b1;
        hit_row     = star_prefix;
        text_seen   = 1'b0;
      end
      wpm_pkg::OP_APPEND: begin
        if (text_seen) begin
          st = wpm_pkg::ST_LATE;
        end else if (pat_len >= MAXP) begin
          st = wpm_pkg::ST_FULL;
        end else begin
          pat_mem[pat_len] = ch;
          star_prefix[pat_len + 1] =
            star_prefix[pat_len] && (ch == wpm_pkg::CHAR_ANY);
          hit_row[pat_len + 1] = star_prefix[pat_len + 1];
          pat_len++;
        end
      end
      wpm_pkg::OP_RESTART: begin
        hit_row   = star_prefix;
        text_seen = 1'b0;
      end
      default: begin
        text_seen = 1'b1;
        nxt = '0;
        for (int j = 1; j <= pat_len; j++) begin
          // a star extends the new bit to its left: runs ripple in one step
          if (pat_mem[j-1] == wpm_pkg::CHAR_ANY)
            nxt[j] = hit_row[j] | nxt[j-1];
          else if (pat_mem[j-1] == wpm_pkg::CHAR_ONE || pat_mem[j-1] == ch)
            nxt[j] = hit_row[j-1];
          else
            nxt[j] = 1'b0;
        end
        hit_row = nxt;
      end
    endcase
    m = hit_row[pat_len];
  endtask

  task automatic push_stim(input wpm_pkg::opcode_t op, input logic [7:0] ch,
                           input bit typed = 1'b0, input logic m = 1'b0,
                           input wpm_pkg::status_t st = wpm_pkg::ST_OK);
    stim_t s;
    s.op = op;
    s.ch = ch;
    s.typed = typed;
    s.m = m;
    s.st = st;
    stim_q.push_back(s);
  endtask

  function automatic logic [7:0] pat_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return wpm_pkg::CHAR_ANY;
    if (r < 55) return wpm_pkg::CHAR_ONE;
    if (r < 90) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 75) return wpm_pkg::CHAR_ANY;
    if (r < 80) return wpm_pkg::CHAR_ONE;
    return 8'($urandom);
  endfunction

  // one session: a clear (most of the time), a pattern, then one to three text runs
  task automatic gen_session();
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    logic [7:0] c;
    int         len;
    int         runs;
    int         k;
    bit         full;
    full = (long_left > 0) && (session_no == 5 || $urandom_range(0, 39) == 0);
    if (full) long_left--;
    session_no++;
    if ($urandom_range(0, 9) != 0) push_stim(wpm_pkg::OP_CLEAR, 8'($urandom));
    if (full)
      len = MAXP + $urandom_range(1, 3);
    else if ($urandom_range(0, 7) == 0)
      len = $urandom_range(0, 24);
    else
      len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      c = pat_byte();
      push_stim(wpm_pkg::OP_APPEND, c);
      if (pat.size() < MAXP) pat.push_back(c);
    end
    runs = $urandom_range(1, 3);
    for (int r = 0; r < runs; r++) begin
      if (r > 0 || $urandom_range(0, 3) == 0)
        push_stim(wpm_pkg::OP_RESTART, 8'($urandom));
      txt.delete();
      if ($urandom_range(0, 9) < 7) begin
        foreach (pat[i]) begin
          if (pat[i] == wpm_pkg::CHAR_ANY) begin
            k = $urandom_range(0, 2);
            repeat (k) txt.push_back(text_byte());
          end else if (pat[i] == wpm_pkg::CHAR_ONE) begin
            txt.push_back(text_byte());
          end else begin
            txt.push_back(pat[i]);
          end
        end
      end else begin
        k = $urandom_range(0, 10);
        repeat (k) txt.push_back(text_byte());
      end
      if (txt.size() > 0 && $urandom_range(0, 3) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = text_byte();
      foreach (txt[i]) begin
        push_stim(wpm_pkg::OP_TEXT, txt[i]);
        // noise: mostly late appends, now and then any request at all
        if ($urandom_range(0, 29) == 0) push_stim(wpm_pkg::OP_APPEND, 8'($urandom));
        if ($urandom_range(0, 79) == 0)
          push_stim(wpm_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  function automatic bit sender_idle(input int ph);
    if (ph == 1) return $urandom_range(0, 99) < 63;
    if (ph == 3) return $urandom_range(0, 99) < 36;
    return 1'b0;
  endfunction

  // response side: check and random stall
  always @(posedge clk) begin : rx
    resp_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        resp_count++;
        if (m_tdata[0]) match_ones++;
        if (m_tdata[2:1] == wpm_pkg::ST_FULL) full_seen++;
        if (m_tdata[2:1] == wpm_pkg::ST_LATE) late_seen++;
        if (expected_resp_q.size() == 0) begin
          $error("unexpected response: match=%0d status=%0d", m_tdata[0], m_tdata[2:1]);
          errors++;
        end else begin
          want = expected_resp_q.pop_front();
          if (m_tdata[0] !== want.m) begin
            $error("match: expected %0d, actual %0d", want.m, m_tdata[0]);
            errors++;
          end
          if (m_tdata[2:1] !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, m_tdata[2:1]);
            errors++;
          end
        end
      end
      if (hold_rx)
        m_tready <= 1'b0;
      else if (cur_phase == 2)
        m_tready <= ($urandom_range(0, 99) >= 63);
      else if (cur_phase == 3)
        m_tready <= ($urandom_range(0, 99) >= 36);
      else
        m_tready <= 1'b1;
    end
  end

  // long output hold-off while requests keep coming, fills the row
  initial begin : backpressure
    wait (n_rand > 0 && item_idx >= n_dir + 40);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (!rst && s_tvalid && !s_tready) in_stalls++;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("** wildcard_pattern_matcher: FAILED **");
    $finish;
  end

  initial begin : main
    logic             pm;
    wpm_pkg::status_t ps;

    // predictor reset state
    pat_len     = 0;
    star_prefix = '0;
    star_prefix[0] = 1'b1;
    hit_row     = star_prefix;
    text_seen   = 1'b0;

    // directed table
    push_stim(wpm_pkg::OP_TEXT,    8'h61, 1, 1'b0, wpm_pkg::ST_OK);   // empty pattern
    push_stim(wpm_pkg::OP_APPEND,  8'h78, 1, 1'b0, wpm_pkg::ST_LATE); // after text
    push_stim(wpm_pkg::OP_RESTART, 8'h00, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_CLEAR,   8'hFF, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_APPEND,  wpm_pkg::CHAR_ANY, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_TEXT,    wpm_pkg::CHAR_ANY, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_TEXT,    8'h00, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_TEXT,    8'hFF, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_APPEND,  8'h61, 1, 1'b1, wpm_pkg::ST_LATE);
    push_stim(wpm_pkg::OP_RESTART, 8'hFF, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_APPEND,  wpm_pkg::CHAR_ONE);
    push_stim(wpm_pkg::OP_APPEND,  8'h00);
    push_stim(wpm_pkg::OP_APPEND,  8'hFF);
    push_stim(wpm_pkg::OP_TEXT,    wpm_pkg::CHAR_ONE);
    push_stim(wpm_pkg::OP_TEXT,    8'h00);
    push_stim(wpm_pkg::OP_TEXT,    8'hFF);
    push_stim(wpm_pkg::OP_TEXT,    8'hFF);
    push_stim(wpm_pkg::OP_CLEAR,   8'h00, 1, 1'b1, wpm_pkg::ST_OK);
    push_stim(wpm_pkg::OP_APPEND,  wpm_pkg::CHAR_ONE);
    push_stim(wpm_pkg::OP_TEXT,    wpm_pkg::CHAR_ANY);
    push_stim(wpm_pkg::OP_TEXT,    8'h62);
    push_stim(wpm_pkg::OP_RESTART, 8'h00);
    push_stim(wpm_pkg::OP_APPEND,  8'h62);
    push_stim(wpm_pkg::OP_CLEAR,   8'h55, 1, 1'b1, wpm_pkg::ST_OK);
    n_dir = stim_q.size();

    while (stim_q.size() - n_dir < N_RANDOM) gen_session();
    n_rand = stim_q.size() - n_dir;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (item_idx < stim_q.size()) begin
      @(posedge clk);
      if (s_tvalid && s_tready) begin
        wildcard_step(stim_q[item_idx].op, stim_q[item_idx].ch, pm, ps);
        if (stim_q[item_idx].typed) begin
          pm = stim_q[item_idx].m;
          ps = stim_q[item_idx].st;
        end
        expected_resp_q.push_back('{pm, ps});
        item_idx++;
        if (item_idx >= n_dir) cur_phase <= (item_idx - n_dir) * 4 / n_rand;
      end
      if (s_tvalid && !s_tready) begin
        // request still pending, hold it
      end else if (item_idx < stim_q.size() && !sender_idle(cur_phase)) begin
        s_tvalid <= 1'b1;
        s_tuser  <= stim_q[item_idx].op;
        s_tdata  <= stim_q[item_idx].ch;
      end else begin
        s_tvalid <= 1'b0;
      end
    end

    while (expected_resp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed), %0d responses, %0d matches",
             stim_q.size(), n_dir, resp_count, match_ones);
    $display("store-full %0d, late append %0d, input stall cycles %0d",
             full_seen, late_seen, in_stalls);
    if (errors == 0) begin
      $display("** wildcard_pattern_matcher: PASSED **");
    end else begin
      $display("** wildcard_pattern_matcher: FAILED **");
    end
    $finish;
  end

endmodule

FILE: wildcard_pattern_matcher.f
+incdir+rtl
rtl/wpm_pkg.sv
rtl/wpm_cell.sv
rtl/wildcard_pattern_matcher.sv
tb/testbench.sv
